FILE: rtl/tscb_pkg.sv
package tscb_pkg;

    typedef enum logic [2:0] {
        CMD_TYPE      = 3'd0,
        CMD_LEFT      = 3'd1,
        CMD_RIGHT     = 3'd2,
        CMD_HOME      = 3'd3,
        CMD_END       = 3'd4,
        CMD_BACKSPACE = 3'd5,
        CMD_TOGGLE    = 3'd6,
        CMD_READ      = 3'd7
    } cmd_t;

    localparam int unsigned IDX_W = 12;
    localparam int unsigned POS_W = 13;

    typedef struct packed {
        cmd_t             cmd;
        logic [7:0]       char_in;
        logic [IDX_W-1:0] read_index;
    } req_t;

    typedef struct packed {
        logic [7:0]       read_char;
        logic             read_valid;
        logic [POS_W-1:0] cursor_pos;
        logic [POS_W-1:0] text_length;
        logic             overwrite_on;
        logic             full_drop;
    } rsp_t;

endpackage

FILE: rtl/tscb_store.sv
module tscb_store #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tscb_ctrl.sv
module tscb_ctrl #(
    parameter int unsigned CAPACITY = 4096,
    parameter int unsigned AW       = 12,
    parameter int unsigned CW       = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tscb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tscb_pkg::rsp_t rsp,
    output logic           b_en,
    output logic           b_we,
    output logic [AW-1:0]  b_addr,
    output logic [7:0]     b_wdata,
    input  logic [7:0]     b_rdata,
    output logic           a_en,
    output logic           a_we,
    output logic [AW-1:0]  a_addr,
    output logic [7:0]     a_wdata,
    input  logic [7:0]     a_rdata
);

    localparam int unsigned IW = (CW > tscb_pkg::IDX_W) ? CW : tscb_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  bc_reg, bc_next;
    logic [CW-1:0]  ac_reg, ac_next;
    logic           ovw_reg, ovw_next;
    logic           right_reg, right_next;
    logic           loop_reg, loop_next;
    logic           drop_reg, drop_next;
    logic           is_read_reg, is_read_next;
    logic           hit_reg, hit_next;
    logic           sel_a_reg, sel_a_next;
    logic           rsp_valid_reg, rsp_valid_next;
    tscb_pkg::rsp_t rsp_reg, rsp_next;

    logic           accept;
    logic [CW-1:0]  total;
    logic [IW-1:0]  idx_w;
    logic [IW-1:0]  bc_w;
    logic [IW-1:0]  ac_w;
    logic [IW-1:0]  idx_off;
    logic [CW-1:0]  src_cnt;
    logic [CW-1:0]  src_dec;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign total     = bc_reg + ac_reg;
    assign idx_w     = IW'(req.read_index);
    assign bc_w      = IW'(bc_reg);
    assign ac_w      = IW'(ac_reg);
    assign idx_off   = idx_w - bc_w;

    // shared step unit for the stack walk
    assign src_cnt   = right_reg ? ac_reg : bc_reg;
    assign src_dec   = src_cnt - CW'(1);

    always_comb
    begin
        b_en    = 1'b0;
        b_we    = 1'b0;
        b_addr  = AW'(bc_reg);
        b_wdata = req.char_in;
        a_en    = 1'b0;
        a_we    = 1'b0;
        a_addr  = AW'(ac_reg);
        a_wdata = b_rdata;

        state_next     = state_reg;
        bc_next        = bc_reg;
        ac_next        = ac_reg;
        ovw_next       = ovw_reg;
        right_next     = right_reg;
        loop_next      = loop_reg;
        drop_next      = drop_reg;
        is_read_next   = is_read_reg;
        hit_next       = hit_reg;
        sel_a_next     = sel_a_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    drop_next    = 1'b0;
                    is_read_next = 1'b0;
                    hit_next     = 1'b0;
                    sel_a_next   = 1'b0;
                    state_next   = S_DONE;
                    case (req.cmd)
                        tscb_pkg::CMD_TYPE:
                        begin
                            if (ovw_reg && (ac_reg != '0))
                            begin
                                b_en    = 1'b1;
                                b_we    = 1'b1;
                                ac_next = ac_reg - CW'(1);
                                bc_next = bc_reg + CW'(1);
                            end
                            else if (total >= CW'(CAPACITY))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                b_en    = 1'b1;
                                b_we    = 1'b1;
                                bc_next = bc_reg + CW'(1);
                            end
                        end
                        tscb_pkg::CMD_LEFT, tscb_pkg::CMD_HOME:
                        begin
                            right_next = 1'b0;
                            loop_next  = (req.cmd == tscb_pkg::CMD_HOME);
                            if (bc_reg != '0)
                            begin
                                state_next = S_MOVE_RD;
                            end
                        end
                        tscb_pkg::CMD_RIGHT, tscb_pkg::CMD_END:
                        begin
                            right_next = 1'b1;
                            loop_next  = (req.cmd == tscb_pkg::CMD_END);
                            if (ac_reg != '0)
                            begin
                                state_next = S_MOVE_RD;
                            end
                        end
                        tscb_pkg::CMD_BACKSPACE:
                        begin
                            if (bc_reg != '0)
                            begin
                                bc_next = bc_reg - CW'(1);
                            end
                        end
                        tscb_pkg::CMD_TOGGLE:
                        begin
                            ovw_next = !ovw_reg;
                        end
                        tscb_pkg::CMD_READ:
                        begin
                            is_read_next = 1'b1;
                            if (idx_w < bc_w)
                            begin
                                b_en     = 1'b1;
                                b_addr   = AW'(idx_w);
                                hit_next = 1'b1;
                            end
                            else if (idx_off < ac_w)
                            begin
                                a_en       = 1'b1;
                                a_addr     = AW'(ac_w - IW'(1) - idx_off);
                                hit_next   = 1'b1;
                                sel_a_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MOVE_RD:
            begin
                if (right_reg)
                begin
                    a_en    = 1'b1;
                    a_addr  = AW'(src_dec);
                    ac_next = src_dec;
                end
                else
                begin
                    b_en    = 1'b1;
                    b_addr  = AW'(src_dec);
                    bc_next = src_dec;
                end
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                if (right_reg)
                begin
                    b_en    = 1'b1;
                    b_we    = 1'b1;
                    b_addr  = AW'(bc_reg);
                    b_wdata = a_rdata;
                    bc_next = bc_reg + CW'(1);
                end
                else
                begin
                    a_en    = 1'b1;
                    a_we    = 1'b1;
                    a_addr  = AW'(ac_reg);
                    a_wdata = b_rdata;
                    ac_next = ac_reg + CW'(1);
                end
                if (loop_reg && (src_cnt != '0))
                begin
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.read_valid   = is_read_reg && hit_reg;
                    rsp_next.read_char    = !(is_read_reg && hit_reg) ? 8'd0 :
                                            (sel_a_reg ? a_rdata : b_rdata);
                    rsp_next.cursor_pos   = tscb_pkg::POS_W'(bc_reg);
                    rsp_next.text_length  = tscb_pkg::POS_W'(total);
                    rsp_next.overwrite_on = ovw_reg;
                    rsp_next.full_drop    = drop_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bc_reg        <= '0;
            ac_reg        <= '0;
            ovw_reg       <= 1'b0;
            right_reg     <= 1'b0;
            loop_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            is_read_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            sel_a_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            ac_reg        <= ac_next;
            ovw_reg       <= ovw_next;
            right_reg     <= right_next;
            loop_reg      <= loop_next;
            drop_reg      <= drop_next;
            is_read_reg   <= is_read_next;
            hit_reg       <= hit_next;
            sel_a_reg     <= sel_a_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/two_stack_cursor_text_buffer.sv
// Line-edit buffer held as two stacks of CAPACITY bytes, one single-port memory each,
// with a sequencer and one shared step unit moving characters between them. Type,
// backspace, toggle and read go from idle straight to the done state, where the response
// is loaded into the output register once it is free; left and right first pass through
// the move-read and move-write states, or go straight to done when there is nothing to
// carry; home and end repeat the move-read and move-write states for each character carried
// across the cursor, since each carried character costs a read of one stack and a write of
// the other. The request side is not ready until the response of the current transaction is
// loaded into the output register; a waiting response does not block the next request.
module two_stack_cursor_text_buffer #(
    parameter int unsigned CAPACITY = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tscb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tscb_pkg::rsp_t rsp
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic          b_en, b_we, a_en, a_we;
    logic [AW-1:0] b_addr, a_addr;
    logic [7:0]    b_wdata, b_rdata, a_wdata, a_rdata;

    tscb_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .b_en      (b_en),
        .b_we      (b_we),
        .b_addr    (b_addr),
        .b_wdata   (b_wdata),
        .b_rdata   (b_rdata),
        .a_en      (a_en),
        .a_we      (a_we),
        .a_addr    (a_addr),
        .a_wdata   (a_wdata),
        .a_rdata   (a_rdata)
    );

    // characters before the cursor, document order
    tscb_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_before (
        .clk   (clk),
        .en    (b_en),
        .we    (b_we),
        .addr  (b_addr),
        .wdata (b_wdata),
        .rdata (b_rdata)
    );

    // characters after the cursor, top is next to the cursor
    tscb_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_after (
        .clk   (clk),
        .en    (a_en),
        .we    (a_we),
        .addr  (a_addr),
        .wdata (a_wdata),
        .rdata (a_rdata)
    );

endmodule

FILE: rtl/tscb_checker.sv
module tscb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input tscb_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input tscb_pkg::rsp_t rsp
);

    // response held while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one transaction in flight at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // a miss or a non-read returns a zero character
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.read_valid |-> rsp.read_char == 8'd0)
        else $error("character on a miss");

    // a dropped character is never a read
    a_drop_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.full_drop |-> !rsp.read_valid)
        else $error("drop flagged on a read");

endmodule

bind two_stack_cursor_text_buffer tscb_checker u_checker (.*);
